// ===== rtl/core/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;
    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TIME_W    = 24;
    localparam int SLOT_W    = 6;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] task_arrival;
        logic [15:0] task_burst;
        logic [7:0]  task_priority;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] running_task;
        logic              cpu_idle;
        logic              task_finished;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_done;
        logic [TIME_W-1:0] time_now;
    } rsp_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_UPDATE
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/pps_front.sv =====
// Front stage: accept request transactions and drop unused commands.
`default_nettype none
module pps_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire pps_pkg::req_t req,
    output logic               push_valid,
    input  wire logic          push_stall,
    output pps_pkg::req_t      push_item
);
    logic          vld_reg, vld_next;
    pps_pkg::req_t item_reg, item_next;
    logic          take;

    assign req_stall  = vld_reg && push_stall;
    assign take       = req_valid && !req_stall;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (vld_reg && !push_stall)
        begin
            vld_next = 1'b0;
        end
        if (take && req.cmd != pps_pkg::CMD_NONE)
        begin
            vld_next  = 1'b1;
            item_next = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end
endmodule
`default_nettype wire

// ===== rtl/core/pps_queue.sv =====
// Two-entry queue between front and back stages.
`default_nettype none
module pps_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_stall,
    input  wire pps_pkg::req_t wr_item,
    output logic               rd_valid,
    input  wire logic          rd_pop,
    output pps_pkg::req_t      rd_item
);
    pps_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pps_back.sv =====
// Back stage: task table, selection scan, service update and result register.
`default_nettype none
module pps_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire pps_pkg::req_t q_item,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pps_pkg::rsp_t      rsp
);
    localparam int N  = pps_pkg::MAX_TASKS;
    localparam int IW = pps_pkg::IDX_W;
    localparam int CW = pps_pkg::CNT_W;
    localparam int TW = pps_pkg::TIME_W;

    pps_pkg::entry_t mem [N];
    pps_pkg::entry_t rd_data_reg;

    pps_pkg::state_t state_reg, state_next;
    pps_pkg::req_t   item_reg, item_next;
    logic [CW-1:0]   task_cnt_reg, task_cnt_next;
    logic [CW-1:0]   fin_cnt_reg, fin_cnt_next;
    logic [TW-1:0]   time_reg, time_next;
    logic [N-1:0]    done_reg, done_next;
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    pps_pkg::entry_t best_reg, best_next;
    logic            out_vld_reg, out_vld_next;
    pps_pkg::rsp_t   out_reg, out_next;

    logic            rd_en;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    pps_pkg::entry_t mem_wdata;
    logic            cand;
    logic            better;
    logic [TW-1:0]   time_inc;
    logic [TW-1:0]   tat;
    logic [TW-1:0]   burst_ext;

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    assign cand = !done_reg[rd_idx_reg] && (TW'(rd_data_reg.arrival) <= time_reg);
    assign better = !found_reg
        || (rd_data_reg.prio < best_reg.prio)
        || (rd_data_reg.prio == best_reg.prio
            && rd_data_reg.arrival < best_reg.arrival);
    assign time_inc  = (time_reg == pps_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);
    assign tat       = time_inc - TW'(best_reg.arrival);
    assign burst_ext = TW'(best_reg.burst);

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        task_cnt_next = task_cnt_reg;
        fin_cnt_next  = fin_cnt_reg;
        time_next     = time_reg;
        done_next     = done_reg;
        scan_idx_next = scan_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        out_vld_next  = out_vld_reg && rsp_stall;
        out_next      = out_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = best_idx_reg;
        mem_wdata     = best_reg;

        if (rd_vld_reg && cand && better)
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_next     = rd_data_reg;
        end

        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    unique case (q_item.cmd)
                        pps_pkg::CMD_LOAD:  state_next = pps_pkg::ST_LOAD;
                        pps_pkg::CMD_CLEAR: state_next = pps_pkg::ST_CLEAR;
                        pps_pkg::CMD_TICK:
                        begin
                            state_next    = pps_pkg::ST_SCAN;
                            scan_idx_next = '0;
                            found_next    = 1'b0;
                        end
                        default:            state_next = pps_pkg::ST_IDLE;
                    endcase
                end
            end
            pps_pkg::ST_LOAD:
            begin
                if (task_cnt_reg < CW'(N))
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = task_cnt_reg[IW-1:0];
                    mem_wdata.arrival   = item_reg.task_arrival;
                    mem_wdata.burst     = item_reg.task_burst;
                    mem_wdata.remaining = item_reg.task_burst;
                    mem_wdata.prio      = item_reg.task_priority;
                    done_next[task_cnt_reg[IW-1:0]] = 1'b0;
                    task_cnt_next       = task_cnt_reg + CW'(1);
                end
                state_next = pps_pkg::ST_IDLE;
            end
            pps_pkg::ST_CLEAR:
            begin
                task_cnt_next = '0;
                fin_cnt_next  = '0;
                time_next     = '0;
                done_next     = '0;
                state_next    = pps_pkg::ST_IDLE;
            end
            pps_pkg::ST_SCAN:
            begin
                if (scan_idx_reg < task_cnt_reg)
                begin
                    rd_en         = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = pps_pkg::ST_UPDATE;
                end
            end
            pps_pkg::ST_UPDATE:
            begin
                if (!out_vld_reg || !rsp_stall)
                begin
                    time_next              = time_inc;
                    out_vld_next           = 1'b1;
                    out_next.running_task  = '0;
                    out_next.cpu_idle      = 1'b1;
                    out_next.task_finished = 1'b0;
                    out_next.turnaround_time = '0;
                    out_next.waiting_time  = '0;
                    out_next.all_done      = (fin_cnt_reg == task_cnt_reg);
                    out_next.time_now      = time_inc;
                    if (found_reg)
                    begin
                        out_next.running_task = pps_pkg::SLOT_W'(best_idx_reg);
                        out_next.cpu_idle     = 1'b0;
                        mem_we                = 1'b1;
                        if (best_reg.remaining <= 16'd1)
                        begin
                            mem_wdata.remaining      = '0;
                            done_next[best_idx_reg]  = 1'b1;
                            fin_cnt_next             = fin_cnt_reg + CW'(1);
                            out_next.task_finished   = 1'b1;
                            out_next.turnaround_time = tat;
                            out_next.waiting_time    = (tat >= burst_ext) ? tat - burst_ext : '0;
                            out_next.all_done = ((fin_cnt_reg + CW'(1)) == task_cnt_reg);
                        end
                        else
                        begin
                            mem_wdata.remaining = best_reg.remaining - 16'd1;
                        end
                    end
                    state_next = pps_pkg::ST_IDLE;
                end
            end
            default: state_next = pps_pkg::ST_IDLE;
        endcase
    end

    assign rd_vld_next = rd_en;
    assign rd_idx_next = scan_idx_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pps_pkg::ST_IDLE;
            task_cnt_reg <= '0;
            fin_cnt_reg  <= '0;
            time_reg     <= '0;
            done_reg     <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            task_cnt_reg <= task_cnt_next;
            fin_cnt_reg  <= fin_cnt_next;
            time_reg     <= time_next;
            done_reg     <= done_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_idx_reg[IW-1:0]];
        end
    end

`ifndef SYNTH
    a_fin_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        fin_cnt_reg <= task_cnt_reg)
        else $error("finished count exceeds task count");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        task_cnt_reg <= CW'(N))
        else $error("task count exceeds table size");
    a_idle_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.cpu_idle |-> !out_reg.task_finished)
        else $error("idle tick reports completion");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pps_pkg::ST_SCAN |-> scan_idx_reg <= task_cnt_reg)
        else $error("scan index past task count");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
// Load and clear pass through the front register, the queue and their own back-stage state;
// a tick result follows a scan of the task table memory at one entry per cycle and the update
// step, which waits while the registered result is stalled.
// The back stage is busy until the tick completes; front register and queue take
// up to three further transactions while a tick runs.
// Reset empties the table, clears all completion flags and sets time to zero.
`default_nettype none
module preemptive_priority_scheduler (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire pps_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pps_pkg::rsp_t      rsp
);
    logic          f_valid;
    logic          f_stall;
    pps_pkg::req_t f_item;
    logic          q_valid;
    logic          q_pop;
    pps_pkg::req_t q_item;

    pps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .push_valid (f_valid),
        .push_stall (f_stall),
        .push_item  (f_item)
    );

    pps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    pps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire
